### rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every enabled clock edge.
`define AST_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Condition that must never be true.
`define AST_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define AST_PROP(lbl, clk, rstn, prop)
`define AST_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### rtl/nrbf_pkg.sv
package nrbf_pkg;

    localparam int DEF_MAX_BASES = 32;
    // Basis index width that covers the whole parameter range.
    localparam int IDX_W = 6;
    // Feature sum width: 17 bit features summed over up to 64 bases.
    localparam int SUM_W = 17 + IDX_W;
    // Divider: 80 bit dividend, 64 bit divisor.
    localparam int DIV_W  = 80;
    localparam int DEN_W  = 64;
    localparam int DIV_CW = $clog2(DIV_W);

    typedef logic [1:0] t_func;
    localparam t_func FN_WRITE = 2'd0;
    localparam t_func FN_EVAL  = 2'd1;
    localparam t_func FN_TRAIN = 2'd2;
    localparam t_func FN_FIT   = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status STS_OK      = 2'd0;
    localparam t_status STS_NOACT   = 2'd1;
    localparam t_status STS_ZERODEN = 2'd2;
    localparam t_status STS_SAT     = 2'd3;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_ACTIVE = 2'd0;
    localparam t_reg_idx REG_FIRST  = 2'd1;
    localparam t_reg_idx REG_STEP   = 2'd2;
    localparam t_reg_idx REG_SCALE  = 2'd3;

    // Per-basis state that travels around the ring.
    typedef struct packed {
        logic [31:0] weight;
        logic [63:0] num;
        logic [63:0] den;
        logic [16:0] feat;
    } t_cell;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    // exp(-k) in Q16.16.
    function automatic logic [16:0] int_tab(input logic [3:0] k);
        logic [16:0] v;
        unique case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-j/16) in Q16.16.
    function automatic logic [16:0] frac_tab(input logic [3:0] j);
        logic [16:0] v;
        unique case (j)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd61565;
            4'd2:  v = 17'd57835;
            4'd3:  v = 17'd54331;
            4'd4:  v = 17'd51039;
            4'd5:  v = 17'd47947;
            4'd6:  v = 17'd45042;
            4'd7:  v = 17'd42313;
            4'd8:  v = 17'd39750;
            4'd9:  v = 17'd37341;
            4'd10: v = 17'd35079;
            4'd11: v = 17'd32954;
            4'd12: v = 17'd30957;
            4'd13: v = 17'd29081;
            4'd14: v = 17'd27319;
            4'd15: v = 17'd25664;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // Apply a sign to a quotient magnitude and clamp to signed 32 bit.
    // Bit 32 of the result flags saturation.
    function automatic logic [32:0] clamp32(input logic neg, input logic [DIV_W-1:0] q);
        logic [32:0] r;
        if (!neg) begin
            if (q > DIV_W'(32'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
            else r = {1'b0, q[31:0]};
        end else begin
            if (q > DIV_W'(32'h8000_0000)) r = {1'b1, 32'h8000_0000};
            else r = {1'b0, 32'd0 - q[31:0]};
        end
        return r;
    endfunction

    // Signed 64 bit add that clamps; bit 64 flags saturation.
    function automatic logic [64:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        logic [64:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            r = s[64] ? {1'b1, 64'h8000_0000_0000_0000} : {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
        end else begin
            r = {1'b0, s[63:0]};
        end
        return r;
    endfunction

endpackage

### rtl/nrbf_cell.sv
module nrbf_cell
    import nrbf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_cell i_d,
    output t_cell o_q
);

    t_cell r_q;

    // Hold this basis and take the neighbor's contents when the ring moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

### rtl/nrbf_div.sv
module nrbf_div
    import nrbf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_dsr;
    logic [DIV_W-1:0]  r_quo;

    logic [DEN_W:0]    rem_sh;
    logic              take;
    logic [DEN_W:0]    rem_sub;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        take    = rem_sh >= {1'b0, r_dsr};
        rem_sub = rem_sh - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_W - 1);
                r_rem  <= '0;
                r_dsr  <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], take};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

### rtl/nrbf_feature.sv
module nrbf_feature
    import nrbf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [IDX_W-1:0] i_index,
    input  logic [31:0]      i_x,
    input  logic [31:0]      i_first,
    input  logic [30:0]      i_step,
    input  logic [31:0]      i_scale,
    output logic             o_valid,
    output logic [16:0]      o_feat
);

    logic [6:0] r_v;

    logic [31:0] r_a_ad;
    logic        r_a_far;
    logic [47:0] r_b_dd;
    logic        r_b_far;
    logic [63:0] r_c_plo;
    logic [15:0] r_c_dhi;
    logic        r_c_far;
    logic [47:0] r_d_phi;
    logic [47:0] r_d_plo;
    logic        r_d_far;
    logic [3:0]  r_e_k;
    logic [3:0]  r_e_j;
    logic [11:0] r_e_r;
    logic        r_e_big;
    logic        r_e_far;
    logic [16:0] r_f_v;
    logic [11:0] r_f_r;
    logic        r_f_zero;
    logic        r_f_far;
    logic [16:0] r_g_f;

    logic [36:0]        ofs;
    logic signed [39:0] ctr;
    logic signed [39:0] delta;
    logic [39:0]        adist;
    logic [63:0]        sq;
    logic [63:0]        expo;
    logic [33:0]        tprod;
    logic [33:0]        fprod;

    // Distance to the center of this basis, plus the square, exponent sum and table products for the stages below.
    always_comb begin
        ofs   = 37'(i_index) * 37'(i_step);
        ctr   = 40'($signed(i_first)) + $signed({3'b000, ofs});
        delta = 40'($signed(i_x)) - ctr;
        adist = delta[39] ? 40'(-delta) : 40'(delta);
        sq    = 64'(r_a_ad) * 64'(r_a_ad);
        expo  = {r_d_phi, 16'h0000} + {16'h0000, r_d_plo};
        tprod = 34'(int_tab(r_e_k)) * 34'(frac_tab(r_e_j));
        fprod = 34'(r_f_v) * 34'(17'd65536 - {5'b00000, r_f_r});
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    // Squared distance, scaling, table lookup and linear correction, at most one
    // multiplication per stage.
    always_ff @(posedge i_clk) begin
        r_a_ad   <= adist[31:0];
        r_a_far  <= |adist[39:32];
        r_b_dd   <= sq[63:16];
        r_b_far  <= r_a_far;
        r_c_plo  <= 64'(r_b_dd[31:0]) * 64'(i_scale);
        r_c_dhi  <= r_b_dd[47:32];
        r_c_far  <= r_b_far;
        r_d_phi  <= 48'(r_c_dhi) * 48'(i_scale);
        r_d_plo  <= r_c_plo[63:16];
        r_d_far  <= r_c_far;
        r_e_k    <= expo[19:16];
        r_e_j    <= expo[15:12];
        r_e_r    <= expo[11:0];
        r_e_big  <= expo >= 64'(32'd12 << 16);
        r_e_far  <= r_d_far;
        r_f_v    <= tprod[32:16];
        r_f_r    <= r_e_r;
        r_f_zero <= r_e_big;
        r_f_far  <= r_e_far;
        if (r_f_far) begin
            r_g_f <= (i_scale == 32'd0) ? 17'd65536 : 17'd0;
        end else if (r_f_zero) begin
            r_g_f <= 17'd0;
        end else begin
            r_g_f <= fprod[32:16];
        end
    end

    assign o_valid = r_v[6];
    assign o_feat  = r_g_f;

endmodule

### rtl/normalized_rbf_approximator.sv
// Normalized Gaussian RBF approximator, Q16.16 fixed point.
// Input channel: i_in_valid / o_in_stall with i_func, i_basis_index,
// i_weight_value, i_x_value and i_y_value. One request is worked at a time;
// o_in_stall is low only while the block is idle.
// Output channel: o_out_valid / i_out_stall with o_result_value and o_status,
// one result per request, held in an output register until it is taken.
// The next request is accepted while that result still waits.
// Basis state sits in a ring of MAX_BASES cells that rotates past one shared
// feature pipeline, shared multipliers and an 80 step divider; every pass turns
// the ring once (MAX_BASES steps). With n active bases:
//   write weight: one pass over the ring
//   evaluate:     one pass that sends each active basis through the
//                 7 stage feature pipeline, then the final division
//   train:        the feature pass plus a second pass with the per-basis
//                 normalizing divisions
//   finish fit:   one pass, one division per active basis with a nonzero denominator
// Reset clears the weights and accumulators at once; no clearing pass.
// While the receiver stalls, a finished request waits for the output
// register and accepts nothing new.
// Configuration: APB, registers at byte addresses 0, 4, 8, 12.
`include "assert_macros.svh"

module normalized_rbf_approximator
    import nrbf_pkg::*;
#(
    parameter int MAX_BASES = DEF_MAX_BASES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_basis_index,
    input  logic [31:0] i_weight_value,
    input  logic [31:0] i_x_value,
    input  logic [31:0] i_y_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_value,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_WRITE, ST_XY, ST_XX, ST_FISSUE, ST_FWAIT, ST_FMUL, ST_FACC,
        ST_FEND, ST_EDIV, ST_EWAIT, ST_GDIV, ST_GWAIT, ST_TMULN, ST_TMULD,
        ST_TACC, ST_FITSTEP, ST_FITWAIT, ST_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [5:0]  r_active;
    logic [31:0] r_first;
    logic [30:0] r_step;
    logic [31:0] r_scale;

    // Latched request and working registers.
    t_func               r_func;
    logic [4:0]          r_idx;
    logic [31:0]         r_wv;
    logic signed [31:0]  r_x;
    logic signed [31:0]  r_y;
    logic [CW-1:0]       r_cnt;
    logic signed [47:0]  r_xy;
    logic signed [47:0]  r_xx;
    logic [16:0]         r_f;
    logic signed [49:0]  r_prod;
    logic [SUM_W-1:0]    r_s;
    logic signed [63:0]  r_acc;
    logic [16:0]         r_g;
    logic [63:0]         r_pn;
    logic [63:0]         r_pd;
    logic                r_sat;
    logic                r_zd;
    logic [31:0]         r_res;
    t_status             r_sts;
    logic                r_out_valid;
    logic [31:0]         r_out_res;
    t_status             r_out_sts;

    t_cell    cell_q [MAX_BASES];
    t_cell    head;
    t_cell    head_new;
    logic     ring_shift;
    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     feat_valid;
    logic     feat_o_valid;
    logic [16:0] feat_o;

    logic [6:0]         n_bases;
    logic               act;
    logic               last;
    logic               cfg_wr;
    logic               out_load;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_xx;
    logic signed [47:0] mul_ga;
    logic signed [65:0] mul_g;
    logic [64:0]        add_n;
    logic [64:0]        add_d;
    logic               t_ov;
    logic               clamp_neg;
    logic [32:0]        clamp_q;
    logic [63:0]        mag_acc;
    logic [63:0]        mag_num;
    logic [63:0]        mag_den;
    logic               zd_now;
    logic               sat_now;

    // APB configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_ACTIVE: prdata = {26'd0, r_active};
            REG_FIRST:  prdata = r_first;
            REG_STEP:   prdata = {1'b0, r_step};
            REG_SCALE:  prdata = r_scale;
            default:    prdata = 32'd0;
        endcase
    end

    // Ring of basis cells; cell 0 is the one under the shared units.
    for (genvar k = 0; k < MAX_BASES; k++) begin : g_ring
        t_cell cell_d;
        if (k == MAX_BASES - 1) begin : g_tail
            assign cell_d = head_new;
        end else begin : g_mid
            assign cell_d = cell_q[k+1];
        end
        nrbf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (ring_shift),
            .i_d     (cell_d),
            .o_q     (cell_q[k])
        );
    end

    assign head = cell_q[0];

    nrbf_feature u_feature (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (feat_valid),
        .i_index (IDX_W'(r_cnt)),
        .i_x     (r_x),
        .i_first (r_first),
        .i_step  (r_step),
        .i_scale (r_scale),
        .o_valid (feat_o_valid),
        .o_feat  (feat_o)
    );

    nrbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Shared arithmetic and pass bookkeeping.
    always_comb begin
        n_bases   = (7'(r_active) > 7'(MAX_BASES)) ? 7'(MAX_BASES) : 7'(r_active);
        act       = 7'(r_cnt) < n_bases;
        last      = r_cnt == CW'(MAX_BASES - 1);
        out_load  = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
        mul_b     = (r_state == ST_XY) ? r_y : r_x;
        mul_xx    = r_x * mul_b;
        mul_ga    = (r_state == ST_TMULN) ? r_xy : r_xx;
        mul_g     = mul_ga * $signed({1'b0, r_g});
        add_n     = sat_add64(head.num, r_pn);
        add_d     = sat_add64(head.den, r_pd);
        t_ov      = (r_state == ST_TACC) && (add_n[64] || add_d[64]);
        mag_acc   = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
        mag_num   = head.num[63] ? (64'd0 - head.num) : head.num;
        mag_den   = head.den[63] ? (64'd0 - head.den) : head.den;
        clamp_neg = (r_state == ST_EWAIT) ? r_acc[63] : (head.num[63] ^ head.den[63]);
        clamp_q   = clamp32(clamp_neg, div_rsp.quotient);
        zd_now    = r_zd || ((r_state == ST_FITSTEP) && act && (head.den == 64'd0));
        sat_now   = r_sat || t_ov ||
                    ((r_state == ST_FITWAIT) && div_rsp.done && clamp_q[32]);
    end

    // Ring update and unit requests for the current step.
    always_comb begin
        ring_shift = 1'b0;
        head_new   = head;
        div_req    = '0;
        feat_valid = 1'b0;
        unique case (r_state)
            ST_WRITE: begin
                ring_shift = 1'b1;
                if (7'(r_cnt) == 7'(r_idx)) head_new.weight = r_wv;
            end
            ST_FISSUE: begin
                if (act) feat_valid = 1'b1;
                else ring_shift = 1'b1;
            end
            ST_FACC: begin
                ring_shift    = 1'b1;
                head_new.feat = r_f;
            end
            ST_EDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(mag_acc);
                div_req.divisor  = DEN_W'(r_s);
            end
            ST_GDIV: begin
                if (act) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'({head.feat, 16'h0000});
                    div_req.divisor  = DEN_W'(r_s);
                end else begin
                    ring_shift = 1'b1;
                end
            end
            ST_TACC: begin
                ring_shift   = 1'b1;
                head_new.num = add_n[63:0];
                head_new.den = add_d[63:0];
            end
            ST_FITSTEP: begin
                if (act && (head.den != 64'd0)) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {mag_num, 16'h0000};
                    div_req.divisor  = mag_den;
                end else begin
                    ring_shift = 1'b1;
                    if (act) head_new.weight = 32'd0;
                    head_new.num = 64'd0;
                    head_new.den = 64'd0;
                end
            end
            ST_FITWAIT: begin
                if (div_rsp.done) begin
                    ring_shift      = 1'b1;
                    head_new.weight = clamp_q[31:0];
                    head_new.num    = 64'd0;
                    head_new.den    = 64'd0;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 6'd10;
            r_first     <= 32'd0;
            r_step      <= 31'd7282;
            r_scale     <= 32'd32768;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (t_reg_idx'(paddr[3:2]))
                    REG_ACTIVE: r_active <= pwdata[5:0];
                    REG_FIRST:  r_first  <= pwdata;
                    REG_STEP:   r_step   <= pwdata[30:0];
                    REG_SCALE:  r_scale  <= pwdata;
                    default: begin
                    end
                endcase
            end

            // The output register refills from a finished request or empties when taken.
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_res   <= r_res;
                r_out_sts   <= r_sts;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_func <= i_func;
                        r_idx  <= i_basis_index;
                        r_wv   <= i_weight_value;
                        r_x    <= i_x_value;
                        r_y    <= i_y_value;
                        r_cnt  <= '0;
                        r_s    <= '0;
                        r_acc  <= '0;
                        r_sat  <= 1'b0;
                        r_zd   <= 1'b0;
                        r_res  <= 32'd0;
                        r_sts  <= STS_OK;
                        unique case (i_func)
                            FN_WRITE: r_state <= ST_WRITE;
                            FN_EVAL:  r_state <= ST_XY;
                            FN_TRAIN: r_state <= ST_XY;
                            FN_FIT:   r_state <= ST_FITSTEP;
                            default:  r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_WRITE: begin
                    if (last) begin
                        r_cnt   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_XY: begin
                    r_xy    <= mul_xx[63:16];
                    r_state <= ST_XX;
                end
                ST_XX: begin
                    r_xx    <= mul_xx[63:16];
                    r_state <= ST_FISSUE;
                end
                ST_FISSUE: begin
                    if (act) begin
                        r_state <= ST_FWAIT;
                    end else if (last) begin
                        r_cnt   <= '0;
                        r_state <= ST_FEND;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_FWAIT: begin
                    if (feat_o_valid) begin
                        r_f     <= feat_o;
                        r_state <= ST_FMUL;
                    end
                end
                ST_FMUL: begin
                    r_prod  <= $signed({1'b0, r_f}) * $signed(head.weight);
                    r_state <= ST_FACC;
                end
                ST_FACC: begin
                    r_s   <= r_s + SUM_W'(r_f);
                    r_acc <= r_acc + 64'(r_prod);
                    if (last) begin
                        r_cnt   <= '0;
                        r_state <= ST_FEND;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= ST_FISSUE;
                    end
                end
                ST_FEND: begin
                    if (r_s == '0) begin
                        r_sts   <= STS_NOACT;
                        r_state <= ST_DONE;
                    end else if (r_func == FN_EVAL) begin
                        r_state <= ST_EDIV;
                    end else begin
                        r_state <= ST_GDIV;
                    end
                end
                ST_EDIV: begin
                    r_state <= ST_EWAIT;
                end
                ST_EWAIT: begin
                    if (div_rsp.done) begin
                        r_res   <= clamp_q[31:0];
                        r_sts   <= clamp_q[32] ? STS_SAT : STS_OK;
                        r_state <= ST_DONE;
                    end
                end
                ST_GDIV: begin
                    if (act) begin
                        r_state <= ST_GWAIT;
                    end else if (last) begin
                        r_cnt   <= '0;
                        r_sts   <= sat_now ? STS_SAT : STS_OK;
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_GWAIT: begin
                    if (div_rsp.done) begin
                        r_g     <= div_rsp.quotient[16:0];
                        r_state <= ST_TMULN;
                    end
                end
                ST_TMULN: begin
                    r_pn    <= mul_g[63:0];
                    r_state <= ST_TMULD;
                end
                ST_TMULD: begin
                    r_pd    <= mul_g[63:0];
                    r_state <= ST_TACC;
                end
                ST_TACC: begin
                    r_sat <= sat_now;
                    if (last) begin
                        r_cnt   <= '0;
                        r_sts   <= sat_now ? STS_SAT : STS_OK;
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= ST_GDIV;
                    end
                end
                ST_FITSTEP, ST_FITWAIT: begin
                    if (div_req.start) begin
                        r_state <= ST_FITWAIT;
                    end else if (ring_shift) begin
                        r_zd  <= zd_now;
                        r_sat <= sat_now;
                        if (last) begin
                            r_cnt   <= '0;
                            r_sts   <= zd_now ? STS_ZERODEN : (sat_now ? STS_SAT : STS_OK);
                            r_state <= ST_DONE;
                        end else begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= ST_FITSTEP;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall     = r_state != ST_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_res;
    assign o_status       = r_out_sts;

    // A new division never starts on top of one in progress.
    `AST_NEVER(a_div_overlap, i_clk, i_rst_n, div_req.start && div_rsp.busy)
    // Features only come back while the sequencer waits for one.
    `AST_PROP(a_feat_wait, i_clk, i_rst_n, feat_o_valid |-> r_state == ST_FWAIT)
    // The ring stays put while no request is being worked.
    `AST_NEVER(a_idle_shift, i_clk, i_rst_n, ring_shift && (r_state == ST_IDLE))
    // A request with no activation reports a zero result.
    `AST_PROP(a_noact_zero, i_clk, i_rst_n, (o_out_valid && o_status == STS_NOACT) |-> !(|o_result_value))

endmodule

### verif/normalized_rbf_approximator_tb.sv
`timescale 1ns / 100ps

module normalized_rbf_approximator_tb;
    import nrbf_pkg::*;

    localparam int NB = DEF_MAX_BASES;

    // Pending input request.
    typedef struct packed {
        t_func       func;
        logic [4:0]  idx;
        logic [31:0] wval;
        logic [31:0] xval;
        logic [31:0] yval;
    } t_req;

    // Expected result.
    typedef struct packed {
        logic [31:0] value;
        t_status     status;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_func = '0;
    logic [4:0]  i_basis_index = '0;
    logic [31:0] i_weight_value = '0;
    logic [31:0] i_x_value = '0;
    logic [31:0] i_y_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_result_value;
    logic [1:0]  o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    normalized_rbf_approximator DUT (.*);

    always #5 i_clk = ~i_clk;

    // Shadow state of the approximator.
    logic [5:0]          cfg_active;
    logic signed [31:0]  cfg_first;
    logic [30:0]         cfg_step;
    logic [31:0]         cfg_scale;
    logic signed [63:0]  weights [NB];
    logic signed [63:0]  num_acc [NB];
    logic signed [63:0]  den_acc [NB];

    t_req    pending_reqs[$];
    t_answer expected_answers[$];
    int      errors = 0;
    int      answers_seen = 0;
    int      hold_off = 0;

    function automatic logic [16:0] exp_int(int k);
        case (k)
            0: return 65536; 1: return 24109; 2: return 8869; 3: return 3263;
            4: return 1200;  5: return 442;   6: return 162;  7: return 60;
            8: return 22;    9: return 8;     10: return 3;   default: return 1;
        endcase
    endfunction

    function automatic logic [16:0] exp_frac(int j);
        logic [16:0] t [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
            42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
        return t[j];
    endfunction

    // Gaussian activation of basis i at point x.
    function automatic logic [63:0] gauss_feature(logic signed [63:0] x, int i);
        logic signed [63:0] c, d;
        logic [63:0] ad, dd, e, v;
        c = 64'(cfg_first) + 64'(i) * 64'(cfg_step);
        d = x - c;
        ad = d < 0 ? -d : d;
        if (ad >= 64'h1_0000_0000) return cfg_scale == 0 ? 65536 : 0;
        dd = (ad * ad) >> 16;
        e = (((dd >> 32) * cfg_scale) << 16) + (((dd & 64'hFFFF_FFFF) * cfg_scale) >> 16);
        if (e >= (64'd12 << 16)) return 0;
        v = (64'(exp_int(int'(e >> 16))) * exp_frac(int'((e >> 12) & 15))) >> 16;
        return (v * (65536 - (e & 12'hFFF))) >> 16;
    endfunction

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                   logic signed [63:0] b, ref bit sat);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin sat = 1; return 64'h7FFF_FFFF_FFFF_FFFF; end
        if (s < -65'sh0_8000_0000_0000_0000) begin sat = 1; return 64'h8000_0000_0000_0000; end
        return s[63:0];
    endfunction

    // Fitted weight num*2^16/den, truncated and clamped.
    function automatic logic signed [63:0] fit_weight(logic signed [63:0] n,
                                                      logic signed [63:0] d, ref bit sat);
        logic [127:0] an, ad, q;
        bit neg;
        an = n < 0 ? 128'(-n) : 128'(n);
        ad = d < 0 ? 128'(-d) : 128'(d);
        if (n == 64'h8000_0000_0000_0000) an = 128'h8000_0000_0000_0000;
        if (d == 64'h8000_0000_0000_0000) ad = 128'h8000_0000_0000_0000;
        neg = (n < 0) != (d < 0);
        q = (an << 16) / ad;
        if (!neg && q > 128'h7FFF_FFFF) begin sat = 1; return 64'sh7FFF_FFFF; end
        if (neg && q > 128'h8000_0000) begin sat = 1; return -64'sh8000_0000; end
        return neg ? -64'(q) : 64'(q);
    endfunction

    // Compute the answer of one request and update the shadow state.
    function automatic t_answer approx_step(t_req r);
        int n;
        logic [63:0] f [NB];
        logic [63:0] s;
        logic signed [63:0] x, y, acc, res, xy, xx, g, pr;
        t_answer a;
        bit sat, zden;
        n = cfg_active > NB ? NB : cfg_active;
        x = 64'(signed'(r.xval));
        y = 64'(signed'(r.yval));
        a = '{value: '0, status: STS_OK};
        s = 0; sat = 0; zden = 0;
        case (r.func)
            FN_WRITE: weights[r.idx] = 64'(signed'(r.wval));
            FN_EVAL, FN_TRAIN: begin
                for (int i = 0; i < n; i++) begin
                    f[i] = gauss_feature(x, i);
                    s += f[i];
                end
                if (s == 0) a.status = STS_NOACT;
                else if (r.func == FN_EVAL) begin
                    acc = 0;
                    for (int i = 0; i < n; i++) acc += signed'(f[i]) * weights[i];
                    res = acc / signed'(s);
                    if (res > 64'sh7FFF_FFFF) begin
                        res = 64'sh7FFF_FFFF; a.status = STS_SAT;
                    end
                    if (res < -64'sh8000_0000) begin
                        res = -64'sh8000_0000; a.status = STS_SAT;
                    end
                    a.value = res[31:0];
                end else begin
                    pr = x * y; xy = pr >>> 16;
                    pr = x * x; xx = pr >>> 16;
                    for (int i = 0; i < n; i++) begin
                        g = signed'((f[i] << 16) / s);
                        num_acc[i] = sat_sum(num_acc[i], xy * g, sat);
                        den_acc[i] = sat_sum(den_acc[i], xx * g, sat);
                    end
                    if (sat) a.status = STS_SAT;
                end
            end
            default: begin
                for (int i = 0; i < n; i++) begin
                    if (den_acc[i] == 0) begin
                        weights[i] = 0; zden = 1;
                    end else begin
                        weights[i] = fit_weight(num_acc[i], den_acc[i], sat);
                    end
                end
                for (int i = 0; i < NB; i++) begin
                    num_acc[i] = 0; den_acc[i] = 0;
                end
                a.status = zden ? STS_ZERODEN : (sat ? STS_SAT : STS_OK);
            end
        endcase
        return a;
    endfunction

    // Driver: one request at a time from the pending queue, random gaps.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_answers.push_back(approx_step(pending_reqs.pop_front()));
                send_gap = $urandom_range(0, 13);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
            end
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (!(i_in_valid && o_in_stall)) begin
                if (pending_reqs.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_func <= pending_reqs[0].func;
                    i_basis_index <= pending_reqs[0].idx;
                    i_weight_value <= pending_reqs[0].wval;
                    i_x_value <= pending_reqs[0].xval;
                    i_y_value <= pending_reqs[0].yval;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result, and stall randomly.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                answers_seen++;
                if (expected_answers.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    want = expected_answers.pop_front();
                    if (o_result_value !== want.value) begin
                        $error("result_value expected %h actual %h", want.value,
                            o_result_value);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, o_status);
                        errors++;
                    end
                end
                stall_left = $urandom_range(0, 13);
                if ($urandom_range(0, 3) == 0) stall_left = 0;
            end
            if (hold_off > 0) begin
                hold_off--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic apb_write(t_reg_idx r, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {r, 2'b00}; pwdata <= v; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            REG_ACTIVE: cfg_active = v[5:0];
            REG_FIRST:  cfg_first = v;
            REG_STEP:   cfg_step = v[30:0];
            default:    cfg_scale = v;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || i_in_valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (3500) @(posedge i_clk);
    endtask

    function automatic t_req rand_req(t_func fn, logic [31:0] lo, logic [31:0] span);
        t_req r;
        r.func = fn;
        r.idx = $urandom;
        r.wval = $urandom;
        if ($urandom_range(0, 1)) r.wval = $signed(r.wval) >>> $urandom_range(0, 14);
        r.xval = lo + ($urandom % (span + 1));
        if ($urandom_range(0, 9) == 0) r.xval = $urandom;
        r.yval = $urandom;
        if ($urandom_range(0, 2) != 0) r.yval = $signed(r.yval) >>> $urandom_range(8, 20);
        return r;
    endfunction

    task automatic push(t_func fn, logic [4:0] ix, logic [31:0] w, logic [31:0] x,
                        logic [31:0] y);
        pending_reqs.push_back('{func: fn, idx: ix, wval: w, xval: x, yval: y});
    endtask

    // Random phase: mostly train/fit/eval cycles over the center range.
    task automatic random_phase(int count);
        logic [31:0] span;
        int k;
        t_func fn;
        span = 32'(cfg_step) * (cfg_active > NB ? NB : cfg_active) + 32'h2_0000;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            fn = k < 15 ? FN_WRITE : k < 55 ? FN_EVAL : k < 90 ? FN_TRAIN : FN_FIT;
            pending_reqs.push_back(rand_req(fn, cfg_first - 32'h1_0000, span));
        end
    endtask

    initial begin
        cfg_active = 10; cfg_first = 0; cfg_step = 7282; cfg_scale = 32768;
        for (int i = 0; i < NB; i++) begin
            weights[i] = 0; num_acc[i] = 0; den_acc[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, every operation and the corner cases.
        push(FN_EVAL, 0, 0, 32'h0000_8000, 0);
        push(FN_FIT, 0, 0, 0, 0);
        push(FN_WRITE, 0, 32'h7FFF_FFFF, 0, 0);
        push(FN_WRITE, 1, 32'h8000_0000, 0, 0);
        push(FN_WRITE, 31, 32'hFFFF_FFFF, 0, 0);
        push(FN_WRITE, 2, 32'h7FFF_FFFF, 0, 0);
        push(FN_EVAL, 0, 0, 32'h0000_0000, 0);
        push(FN_EVAL, 0, 0, 32'h0000_1C72, 0);
        push(FN_EVAL, 0, 0, 32'h7FFF_FFFF, 0);
        push(FN_EVAL, 0, 0, 32'h8000_0000, 0);
        push(FN_TRAIN, 0, 0, 32'h0001_0000, 32'h0002_0000);
        push(FN_TRAIN, 0, 0, 32'hFFFF_0000, 32'h7FFF_FFFF);
        push(FN_TRAIN, 0, 0, 32'h8000_0000, 32'h8000_0000);
        push(FN_TRAIN, 0, 0, 32'h8000_0000, 32'h8000_0000);
        push(FN_TRAIN, 0, 0, 32'h7FFF_FFFF, 0);
        push(FN_FIT, 0, 0, 0, 0);
        push(FN_EVAL, 0, 0, 32'h0000_4000, 0);
        push(FN_TRAIN, 0, 0, 32'h0000_8000, 32'h0001_8000);
        push(FN_FIT, 0, 0, 0, 0);
        push(FN_EVAL, 0, 0, 32'h0000_8000, 0);
        wait_idle();

        // Zero scale: every basis fully active, far points included.
        apb_write(REG_SCALE, 0);
        apb_write(REG_ACTIVE, 63);
        apb_write(REG_FIRST, 32'h8000_0000);
        apb_write(REG_STEP, 31'h7FFF_FFFF);
        push(FN_EVAL, 0, 0, 32'h7FFF_FFFF, 0);
        push(FN_TRAIN, 0, 0, 32'h0003_0000, 32'hFFFE_0000);
        push(FN_FIT, 0, 0, 0, 0);
        random_phase(60);
        wait_idle();

        // No bases at all.
        apb_write(REG_ACTIVE, 0);
        apb_write(REG_SCALE, 32'hFFFF_FFFF);
        push(FN_EVAL, 0, 0, 0, 0);
        push(FN_TRAIN, 0, 0, 0, 0);
        push(FN_FIT, 0, 0, 0, 0);
        wait_idle();

        // Long receiver hold-off while requests keep coming.
        apb_write(REG_ACTIVE, 1);
        apb_write(REG_FIRST, 0);
        apb_write(REG_STEP, 0);
        apb_write(REG_SCALE, 1);
        hold_off = 400;
        random_phase(40);
        wait_idle();

        // Main random phases over several settings.
        for (int p = 0; p < 8; p++) begin
            apb_write(REG_ACTIVE, $urandom_range(0, 3) == 0 ? 32 : $urandom_range(1, 8));
            apb_write(REG_FIRST, $urandom_range(0, 1) ? $urandom : 32'hFFFF_0000);
            apb_write(REG_STEP, $urandom_range(2000, 40000));
            apb_write(REG_SCALE, $urandom_range(0, 3) == 0 ? $urandom
                                                          : $urandom_range(1000, 200000));
            random_phase(p == 7 ? 120 : 230);
            wait_idle();
        end

        $display("Covered all four operations, no-activation, zero denominator and");
        $display("saturation cases over %0d results and a dozen register settings.",
            answers_seen);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("normalized_rbf_approximator regression: pass");
        end else begin
            $display("normalized_rbf_approximator regression: fail");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("normalized_rbf_approximator regression: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/nrbf_pkg.sv
rtl/nrbf_cell.sv
rtl/nrbf_div.sv
rtl/nrbf_feature.sv
rtl/normalized_rbf_approximator.sv
verif/normalized_rbf_approximator_tb.sv
